// ===== rtl/core/kcpe_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kcpe_pkg: shared types and constants
// Register indexes, widths and the request and response structs that pass
// between the sequencer and the shared arithmetic unit.
// ----------------------------------------------------------------------------
package kcpe_pkg;

    localparam int unsigned N_REGS = 8;
    localparam int unsigned ADDR_W = 5;

    localparam logic [2:0] REG_LONG_THR   = 3'd0;
    localparam logic [2:0] REG_SHORT_LEN  = 3'd1;
    localparam logic [2:0] REG_LONG_LEN   = 3'd2;
    localparam logic [2:0] REG_TONE_RAMP  = 3'd3;
    localparam logic [2:0] REG_TONE_PEAK  = 3'd4;
    localparam logic [2:0] REG_LED_RISE   = 3'd5;
    localparam logic [2:0] REG_LED_DECAY  = 3'd6;
    localparam logic [2:0] REG_LED_MINF   = 3'd7;

    // Operations of the shared unit.
    localparam logic [1:0] OP_MUL = 2'd0;
    localparam logic [1:0] OP_DIV = 2'd1;

    typedef struct packed {
        logic        start;
        logic [1:0]  op;
        logic [47:0] a;
        logic [47:0] b;
    } alu_req_t;

    typedef struct packed {
        logic        done;
        logic [47:0] res;
    } alu_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/core/kcpe_alu.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kcpe_alu: shared serial multiplier and divider
// Shift-add multiply and restoring divide, one bit of the 48-bit operands a
// cycle. A quotient by zero is all ones and is never used by the sequencer.
// ----------------------------------------------------------------------------
module kcpe_alu
    import kcpe_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire alu_req_t req,
    output alu_rsp_t      rsp
);

    logic        busy_reg, busy_next;
    logic [1:0]  op_reg, op_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [47:0] a_reg, a_next;
    logic [47:0] b_reg, b_next;
    logic [47:0] acc_reg, acc_next;
    logic        done_reg, done_next;
    logic [48:0] trial;
    logic [47:0] rem_sh;

    always_comb begin
        busy_next = busy_reg;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        done_next = 1'b0;
        rem_sh    = {acc_reg[46:0], a_reg[47]};
        trial     = {1'b0, rem_sh} - {1'b0, b_reg};
        if (req.start) begin
            busy_next = 1'b1;
            op_next   = req.op;
            cnt_next  = 6'd0;
            a_next    = req.a;
            b_next    = req.b;
            acc_next  = '0;
        end else if (busy_reg) begin
            unique case (op_reg)
                OP_MUL: begin
                    // Product bits above 48 are never needed.
                    if (b_reg[0]) begin
                        acc_next = acc_reg + a_reg;
                    end
                    a_next = {a_reg[46:0], 1'b0};
                    b_next = {1'b0, b_reg[47:1]};
                end
                OP_DIV: begin
                    // The accumulator holds the remainder, a shifts into the quotient.
                    if (!trial[48]) begin
                        acc_next = trial[47:0];
                        a_next   = {a_reg[46:0], 1'b1};
                    end else begin
                        acc_next = rem_sh;
                        a_next   = {a_reg[46:0], 1'b0};
                    end
                end
                default: begin
                    acc_next = acc_reg;
                end
            endcase
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd47) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        op_reg  <= op_next;
        cnt_reg <= cnt_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign rsp.done = done_reg;
    assign rsp.res  = (op_reg == OP_DIV) ? a_reg : acc_reg;

`ifndef ASSERT_OFF
    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> !done_reg)
        else $error("alu done held for two cycles");
    a_done_ends_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg || $past(req.start))
        else $error("alu done while still busy");
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> !busy_reg)
        else $error("alu started while busy");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/kcpe_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kcpe_regs: configuration registers
// APB write and read of the eight envelope settings.
// ----------------------------------------------------------------------------
module kcpe_regs
    import kcpe_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    output logic      [15:0]       long_thr,
    output logic      [15:0]       short_len,
    output logic      [15:0]       long_len,
    output logic      [7:0]        tone_ramp,
    output logic      [11:0]       tone_peak,
    output logic      [9:0]        led_rise,
    output logic      [9:0]        led_decay,
    output logic      [7:0]        led_minf
);

    logic [15:0] long_thr_reg, short_len_reg, long_len_reg;
    logic [7:0]  tone_ramp_reg, led_minf_reg;
    logic [11:0] tone_peak_reg;
    logic [9:0]  led_rise_reg, led_decay_reg;
    logic [2:0]  idx;
    logic        wr;

    assign pready = 1'b1;
    assign idx    = paddr[4:2];
    assign wr     = psel && penable && pwrite && (paddr[1:0] == 2'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            long_thr_reg  <= 16'd200;
            short_len_reg <= 16'd150;
            long_len_reg  <= 16'd450;
            tone_ramp_reg <= 8'd8;
            tone_peak_reg <= 12'd3277;
            led_rise_reg  <= 10'd154;
            led_decay_reg <= 10'd563;
            led_minf_reg  <= 8'd12;
        end else if (wr) begin
            unique case (idx)
                REG_LONG_THR:  long_thr_reg  <= pwdata[15:0];
                REG_SHORT_LEN: short_len_reg <= pwdata[15:0];
                REG_LONG_LEN:  long_len_reg  <= pwdata[15:0];
                REG_TONE_RAMP: tone_ramp_reg <= pwdata[7:0];
                REG_TONE_PEAK: tone_peak_reg <= pwdata[11:0];
                REG_LED_RISE:  led_rise_reg  <= pwdata[9:0];
                REG_LED_DECAY: led_decay_reg <= pwdata[9:0];
                REG_LED_MINF:  led_minf_reg  <= pwdata[7:0];
                default:       long_thr_reg  <= long_thr_reg;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[1:0] == 2'd0) begin
            unique case (idx)
                REG_LONG_THR:  prdata = {16'd0, long_thr_reg};
                REG_SHORT_LEN: prdata = {16'd0, short_len_reg};
                REG_LONG_LEN:  prdata = {16'd0, long_len_reg};
                REG_TONE_RAMP: prdata = {24'd0, tone_ramp_reg};
                REG_TONE_PEAK: prdata = {20'd0, tone_peak_reg};
                REG_LED_RISE:  prdata = {22'd0, led_rise_reg};
                REG_LED_DECAY: prdata = {22'd0, led_decay_reg};
                REG_LED_MINF:  prdata = {24'd0, led_minf_reg};
                default:       prdata = '0;
            endcase
        end
    end

    assign long_thr  = long_thr_reg;
    assign short_len = short_len_reg;
    assign long_len  = long_len_reg;
    assign tone_ramp = tone_ramp_reg;
    assign tone_peak = tone_peak_reg;
    assign led_rise  = led_rise_reg;
    assign led_decay = led_decay_reg;
    assign led_minf  = led_minf_reg;

endmodule
`default_nettype wire

// ===== rtl/core/keypress_classified_pulse_envelope.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// keypress_classified_pulse_envelope: key-timed pulse with tone and LED envelopes
// Times key presses, starts a short or long pulse on release and produces a
// trapezoid tone amplitude and an eased LED duty for every tick.
// ----------------------------------------------------------------------------
//  channel   dir   word
//  s_axis    in    one tick: key_down
//  m_axis    out   tone_level, led_duty, pulse_on, pulse_is_long
//  apb       in    eight settings at byte address 4*i
//
// Each product or quotient goes through the shared 48-bit serial multiply and
// divide unit: up to two for the tone and up to eleven on an LED update tick
// in the decay phase with scaled fades. s_tready is low from acceptance until
// the result word has been taken. Reset is synchronous; the control state and
// settings return to their defaults, while the tone, fade, scratch and output
// word registers are not reset.
// ----------------------------------------------------------------------------
module keypress_classified_pulse_envelope
    import kcpe_pkg::*;
#(
    parameter int unsigned LED_UPDATE_TICKS = 2,
    parameter int unsigned DUTY_BITS        = 12
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [7:0]        s_tdata,   // [0] key_down
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic      [31:0]       m_tdata,   // [11:0] tone_level, [23:12] led_duty,
                                              // [24] pulse_on, [25] pulse_is_long
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready
);

    localparam logic [47:0] DMAX = 48'((64'd1 << DUTY_BITS) - 64'd1);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_TONE1 = 5'd1;  // P*t or P*(L-t)
    localparam logic [4:0] S_TONE2 = 5'd2;  // divide by R
    localparam logic [4:0] S_FIN   = 5'd3;  // L*rise
    localparam logic [4:0] S_FOUT  = 5'd4;  // L*decay
    localparam logic [4:0] S_SC1   = 5'd5;  // fin*L
    localparam logic [4:0] S_SC2   = 5'd6;  // /sum
    localparam logic [4:0] S_SC3   = 5'd7;  // fout*L
    localparam logic [4:0] S_SC4   = 5'd8;  // /sum
    localparam logic [4:0] S_SEL   = 5'd9;
    localparam logic [4:0] S_R1    = 5'd10; // t*4096/fin
    localparam logic [4:0] S_R2    = 5'd11; // v*v
    localparam logic [4:0] S_R3    = 5'd12; // *M
    localparam logic [4:0] S_D1    = 5'd13; // x*4096/fout
    localparam logic [4:0] S_D2    = 5'd14; // rq*rq
    localparam logic [4:0] S_D3    = 5'd15; // *rq
    localparam logic [4:0] S_D4    = 5'd16; // *M (split into two halves)
    localparam logic [4:0] S_FIN2  = 5'd17;
    localparam logic [4:0] S_OUT   = 5'd18;
    localparam logic [4:0] S_WAIT  = 5'd19;

    logic [15:0] long_thr, short_len, long_len;
    logic [7:0]  tone_ramp, led_minf;
    logic [11:0] tone_peak;
    logic [9:0]  led_rise, led_decay;

    kcpe_regs u_regs (
        .aclk, .aresetn, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .long_thr, .short_len, .long_len, .tone_ramp, .tone_peak,
        .led_rise, .led_decay, .led_minf
    );

    alu_req_t req;
    alu_rsp_t rsp;

    kcpe_alu u_alu (.aclk, .aresetn, .req, .rsp);

    logic [4:0]  st_reg, st_next;
    logic        wait_reg, wait_next;
    logic        key_prev_reg, key_prev_next;
    logic [15:0] hold_reg, hold_next;
    logic        act_reg, act_next;
    logic        long_reg, long_next;
    logic [15:0] el_reg, el_next;
    logic [3:0]  phase_reg, phase_next;
    logic [11:0] duty_reg, duty_next;
    logic [11:0] tone_reg, tone_next;
    logic        upd_reg, upd_next;
    logic [16:0] fin_reg, fin_next;
    logic [16:0] fout_reg, fout_next;
    logic [47:0] tmp_reg, tmp_next;
    logic        mv_reg, mv_next;
    logic [31:0] mdata_reg, mdata_next;

    logic [15:0] len;
    logic [15:0] t;
    logic [16:0] s_pos;
    logic [17:0] sum;
    logic [4:0]  phase_inc;
    logic [47:0] res;

    assign len   = long_reg ? long_len : short_len;
    assign t     = el_reg;
    assign res   = rsp.res;
    assign sum   = {1'b0, fin_reg} + {1'b0, fout_reg};
    assign s_pos = {1'b0, len} - fout_reg;
    assign phase_inc = {1'b0, phase_reg} + 5'd1;

    function automatic logic [11:0] sat12(input logic [47:0] x);
        sat12 = (x > 48'd4095) ? 12'd4095 : x[11:0];
    endfunction

    always_comb begin
        st_next       = st_reg;
        wait_next     = 1'b0;
        key_prev_next = key_prev_reg;
        hold_next     = hold_reg;
        act_next      = act_reg;
        long_next     = long_reg;
        el_next       = el_reg;
        phase_next    = phase_reg;
        duty_next     = duty_reg;
        tone_next     = tone_reg;
        upd_next      = upd_reg;
        fin_next      = fin_reg;
        fout_next     = fout_reg;
        tmp_next      = tmp_reg;
        mv_next       = mv_reg;
        mdata_next    = mdata_reg;
        req           = '0;

        if (mv_reg && m_tready) begin
            mv_next = 1'b0;
        end

        unique case (st_reg)
            S_IDLE: begin
                if (s_tvalid && !mv_reg) begin
                    if (s_tdata[0]) begin
                        if (!key_prev_reg) hold_next = 16'd1;
                        else if (hold_reg != 16'hFFFF) hold_next = hold_reg + 16'd1;
                    end else if (key_prev_reg) begin
                        long_next = (hold_reg >= long_thr);
                        act_next  = 1'b1;
                        el_next   = 16'd0;
                    end
                    key_prev_next = s_tdata[0];
                    if (32'(phase_inc) >= LED_UPDATE_TICKS) begin
                        phase_next = 4'd0;
                        upd_next   = 1'b1;
                    end else begin
                        phase_next = phase_inc[3:0];
                        upd_next   = 1'b0;
                    end
                    tone_next = 12'd0;
                    st_next   = S_TONE1;
                end
            end
            S_TONE1: begin
                // Registers from the key edge now hold; t and L are stable.
                if (!act_reg || t >= len || tone_ramp == 8'd0) begin
                    tone_next = (!act_reg || t >= len) ? 12'd0 : tone_peak;
                    st_next   = S_FIN;
                end else if (t < {8'd0, tone_ramp}) begin
                    req = '{start: 1'b1, op: OP_MUL, a: 48'(tone_peak), b: 48'(t)};
                    wait_next = 1'b1;
                    st_next   = S_TONE2;
                end else if ({1'b0, t} < {1'b0, len} - {9'd0, tone_ramp}) begin
                    tone_next = tone_peak;
                    st_next   = S_FIN;
                end else begin
                    req = '{start: 1'b1, op: OP_MUL, a: 48'(tone_peak), b: 48'(len - t)};
                    wait_next = 1'b1;
                    st_next   = S_TONE2;
                end
            end
            S_TONE2: begin
                if (wait_reg) begin
                    wait_next = 1'b1;
                    if (rsp.done) begin
                        req = '{start: 1'b1, op: OP_DIV, a: res, b: 48'(tone_ramp)};
                        wait_next = 1'b0;
                        tmp_next  = 48'd1;
                    end
                end else if (rsp.done) begin
                    tone_next = res[11:0];
                    st_next   = S_FIN;
                end
            end
            S_FIN: begin
                if (!upd_reg) begin
                    st_next = S_FIN2;
                end else if (!act_reg || t >= len) begin
                    duty_next = 12'd0;
                    st_next   = S_FIN2;
                end else if (!wait_reg) begin
                    req = '{start: 1'b1, op: OP_MUL, a: 48'(len), b: 48'(led_rise)};
                    wait_next = 1'b1;
                end else begin
                    wait_next = 1'b1;
                    if (rsp.done) begin
                        fin_next  = (res[25:10] < 16'(led_minf)) ? 17'(led_minf)
                                                                 : {1'b0, res[25:10]};
                        wait_next = 1'b0;
                        st_next   = S_FOUT;
                    end
                end
            end
            S_FOUT: begin
                if (!wait_reg) begin
                    req = '{start: 1'b1, op: OP_MUL, a: 48'(len), b: 48'(led_decay)};
                    wait_next = 1'b1;
                end else begin
                    wait_next = 1'b1;
                    if (rsp.done) begin
                        fout_next = (res[25:10] < 16'(led_minf)) ? 17'(led_minf)
                                                                 : {1'b0, res[25:10]};
                        wait_next = 1'b0;
                        st_next   = S_SC1;
                    end
                end
            end
            S_SC1: begin
                if (sum > {2'd0, len}) begin
                    req = '{start: 1'b1, op: OP_MUL, a: 48'(fin_reg), b: 48'(len)};
                    st_next = S_SC2;
                end else begin
                    st_next = S_SEL;
                end
            end
            S_SC2: begin
                if (rsp.done) begin
                    req = '{start: 1'b1, op: OP_DIV, a: res, b: 48'(sum)};
                    st_next = S_SC3;
                end
            end
            S_SC3: begin
                if (rsp.done) begin
                    tmp_next = res;
                    req = '{start: 1'b1, op: OP_MUL, a: 48'(fout_reg), b: 48'(len)};
                    st_next = S_SC4;
                end
            end
            S_SC4: begin
                if (!wait_reg) begin
                    if (rsp.done) begin
                        req = '{start: 1'b1, op: OP_DIV, a: res, b: 48'(sum)};
                        wait_next = 1'b1;
                    end
                end else begin
                    wait_next = 1'b1;
                    if (rsp.done) begin
                        fin_next  = tmp_reg[16:0];
                        fout_next = res[16:0];
                        wait_next = 1'b0;
                        st_next   = S_SEL;
                    end
                end
            end
            S_SEL: begin
                if ({1'b0, t} < fin_reg) begin
                    req = '{start: 1'b1, op: OP_DIV, a: 48'({t, 12'd0}), b: 48'(fin_reg)};
                    st_next = S_R1;
                end else if ({1'b0, t} < s_pos) begin
                    duty_next = sat12(DMAX);
                    st_next   = S_FIN2;
                end else begin
                    req = '{start: 1'b1, op: OP_DIV,
                            a: 48'({fout_reg - ({1'b0, t} - s_pos), 12'd0}),
                            b: 48'(fout_reg)};
                    st_next = S_D1;
                end
            end
            S_R1: begin
                if (rsp.done) begin
                    tmp_next = 48'd4096 - res;
                    st_next  = S_R2;
                end
            end
            S_R2: begin
                if (!wait_reg) begin
                    req = '{start: 1'b1, op: OP_MUL, a: tmp_reg, b: tmp_reg};
                    wait_next = 1'b1;
                end else begin
                    wait_next = 1'b1;
                    if (rsp.done) begin
                        req = '{start: 1'b1, op: OP_MUL, a: 48'd16777216 - res, b: DMAX};
                        wait_next = 1'b0;
                        st_next   = S_R3;
                    end
                end
            end
            S_R3: begin
                if (rsp.done) begin
                    duty_next = sat12({24'd0, res[47:24]});
                    st_next   = S_FIN2;
                end
            end
            S_D1: begin
                if (rsp.done) begin
                    tmp_next = res;
                    req = '{start: 1'b1, op: OP_MUL, a: res, b: res};
                    st_next = S_D2;
                end
            end
            S_D2: begin
                if (rsp.done) begin
                    req = '{start: 1'b1, op: OP_MUL, a: res, b: tmp_reg};
                    st_next = S_D3;
                end
            end
            S_D3: begin
                if (rsp.done) begin
                    // rq^3 fits in 37 bits; keep the product under 48 bits by shifting
                    // the low 12 bits off first and handling them in a second product.
                    tmp_next = res;
                    req = '{start: 1'b1, op: OP_MUL, a: {12'd0, res[47:12]}, b: DMAX};
                    st_next = S_D4;
                end
            end
            S_D4: begin
                if (!wait_reg) begin
                    if (rsp.done) begin
                        fin_next = 17'd0;
                        tmp_next = {res[47:0]};
                        req = '{start: 1'b1, op: OP_MUL, a: {36'd0, tmp_reg[11:0]}, b: DMAX};
                        wait_next = 1'b1;
                    end
                end else begin
                    wait_next = 1'b1;
                    if (rsp.done) begin
                        // floor((hi*2^12 + lo)*M / 2^36) = floor((hi*M + lo*M/2^12) / 2^24)
                        duty_next = sat12(48'((tmp_reg + {12'd0, res[47:12]}) >> 24));
                        wait_next = 1'b0;
                        st_next   = S_FIN2;
                    end
                end
            end
            S_FIN2: begin
                if (act_reg && t >= len) begin
                    act_next = 1'b0;
                end else if (act_reg && el_reg != 16'hFFFF) begin
                    el_next = el_reg + 16'd1;
                end
                st_next = S_OUT;
            end
            S_OUT: begin
                mv_next    = 1'b1;
                mdata_next = {6'd0, long_reg, act_reg, duty_reg, tone_reg};
                st_next    = S_WAIT;
            end
            S_WAIT: begin
                if (!mv_reg || m_tready) begin
                    st_next = S_IDLE;
                end
            end
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg       <= S_IDLE;
            wait_reg     <= 1'b0;
            key_prev_reg <= 1'b0;
            hold_reg     <= 16'd0;
            act_reg      <= 1'b0;
            long_reg     <= 1'b0;
            el_reg       <= 16'd0;
            phase_reg    <= 4'd0;
            duty_reg     <= 12'd0;
            mv_reg       <= 1'b0;
            upd_reg      <= 1'b0;
        end else begin
            st_reg       <= st_next;
            wait_reg     <= wait_next;
            key_prev_reg <= key_prev_next;
            hold_reg     <= hold_next;
            act_reg      <= act_next;
            long_reg     <= long_next;
            el_reg       <= el_next;
            phase_reg    <= phase_next;
            duty_reg     <= duty_next;
            mv_reg       <= mv_next;
            upd_reg      <= upd_next;
        end
        tone_reg  <= tone_next;
        fin_reg   <= fin_next;
        fout_reg  <= fout_next;
        tmp_reg   <= tmp_next;
        mdata_reg <= mdata_next;
    end

    assign s_tready = (st_reg == S_IDLE) && !mv_reg;
    assign m_tvalid = mv_reg;
    assign m_tdata  = mdata_reg;

`ifndef ASSERT_OFF
    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg != S_IDLE) |-> !s_tready)
        else $error("input ready while a tick is in work");
    a_out_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == S_OUT) |=> m_tvalid)
        else $error("result word not presented");
    a_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[24] && $rose(m_tvalid)) |-> (m_tdata[11:0] == 12'd0) ||
        (m_tdata[11:0] == tone_reg))
        else $error("tone word inconsistent");
`endif

endmodule
`default_nettype wire

// ===== bench/kcpe_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kcpe_checker: envelope predictor and result comparator
// Watches the tick and result channels and the register port, predicts the
// tone, LED duty and pulse flags of every accepted tick and compares each
// result word with the oldest prediction.
// ----------------------------------------------------------------------------
module kcpe_checker
    import kcpe_pkg::*;
#(
    parameter int unsigned UPDATE_TICKS = 2,
    parameter int unsigned DUTY_W       = 12
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    input  wire logic              s_tready,
    input  wire logic [7:0]        s_tdata,
    input  wire logic              m_tvalid,
    input  wire logic              m_tready,
    input  wire logic [31:0]       m_tdata,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    input  wire logic              pready,
    output int                     fail_count,
    output int                     pending
);

    logic [15:0] thr_ms, short_ms, long_ms;
    logic [7:0]  ramp_ms, min_fade;
    logic [11:0] peak;
    logic [9:0]  rise_frac, decay_frac;

    logic        key_was;
    logic [15:0] held_ticks;
    logic        active, is_long;
    logic [15:0] elapsed;
    logic [3:0]  phase;
    logic [11:0] duty_held;

    logic [31:0] envelope_q[$];

    assign pending = envelope_q.size();

    function automatic logic [11:0] tone_at(logic [15:0] t, logic [15:0] len);
        longint lr;
        lr = longint'(len) - longint'(ramp_ms);
        if (!active || t >= len) return 0;
        if (t < ramp_ms) return 12'((64'(peak) * t) / ramp_ms);
        if (longint'(t) < lr) return peak;
        if (ramp_ms == 0) return 0;
        return 12'((64'(peak) * (len - t)) / ramp_ms);
    endfunction

    function automatic logic [11:0] duty_at(logic [15:0] t, logic [15:0] len);
        logic [63:0] m, fin, fout, sum, s, d, v, rq;
        m = (64'd1 << DUTY_W) - 1;
        if (!active || t >= len) return 0;
        fin  = (64'(len) * rise_frac) >> 10;
        fout = (64'(len) * decay_frac) >> 10;
        if (fin < min_fade) fin = min_fade;
        if (fout < min_fade) fout = min_fade;
        sum = fin + fout;
        if (sum > len) begin
            fin  = fin * len / sum;
            fout = fout * len / sum;
        end
        s = len - fout;
        if (t < fin) begin
            v = 4096 - (64'(t) * 4096) / fin;
            d = (((64'd1 << 24) - v * v) * m) >> 24;
        end else if (t < s) begin
            d = m;
        end else begin
            rq = ((fout - (t - s)) * 4096) / fout;
            d = (rq * rq * rq * m) >> 36;
        end
        if (d > 4095) d = 4095;
        return 12'(d);
    endfunction

    task automatic advance_tick(input logic key);
        logic [15:0] len, t;
        logic [11:0] tone;
        if (key) begin
            if (!key_was) held_ticks = 1;
            else if (held_ticks != 16'hFFFF) held_ticks++;
        end else if (key_was) begin
            is_long = (held_ticks >= thr_ms);
            active  = 1;
            elapsed = 0;
        end
        key_was = key;
        len  = is_long ? long_ms : short_ms;
        t    = elapsed;
        tone = tone_at(t, len);
        phase++;
        if (phase >= UPDATE_TICKS) begin
            phase = 0;
            duty_held = duty_at(t, len);
        end
        if (active && t >= len) active = 0;
        if (active && elapsed != 16'hFFFF) elapsed++;
        envelope_q.push_back({6'd0, is_long, active, duty_held, tone});
    endtask

    always @(posedge aclk) begin
        logic [31:0] want;
        if (!aresetn) begin
            thr_ms = 200; short_ms = 150; long_ms = 450; ramp_ms = 8; peak = 3277;
            rise_frac = 154; decay_frac = 563; min_fade = 12;
            key_was = 0; held_ticks = 0; active = 0; is_long = 0;
            elapsed = 0; phase = 0; duty_held = 0;
            envelope_q.delete();
            fail_count = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (envelope_q.size() == 0) begin
                    $display("%0t: unexpected word %h", $time, m_tdata);
                    fail_count++;
                end else begin
                    want = envelope_q.pop_front();
                    if (m_tdata[11:0] !== want[11:0] || m_tdata[23:12] !== want[23:12] ||
                        m_tdata[24] !== want[24] || m_tdata[25] !== want[25]) begin
                        $display("%0t: mismatch expected tone %0d duty %0d on %b long %b, actual tone %0d duty %0d on %b long %b",
                                 $time, want[11:0], want[23:12], want[24], want[25],
                                 m_tdata[11:0], m_tdata[23:12], m_tdata[24], m_tdata[25]);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) advance_tick(s_tdata[0]);
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    REG_LONG_THR:  thr_ms     = pwdata[15:0];
                    REG_SHORT_LEN: short_ms   = pwdata[15:0];
                    REG_LONG_LEN:  long_ms    = pwdata[15:0];
                    REG_TONE_RAMP: ramp_ms    = pwdata[7:0];
                    REG_TONE_PEAK: peak       = pwdata[11:0];
                    REG_LED_RISE:  rise_frac  = pwdata[9:0];
                    REG_LED_DECAY: decay_frac = pwdata[9:0];
                    REG_LED_MINF:  min_fade   = pwdata[7:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

// ===== bench/keypress_classified_pulse_envelope_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keypress_classified_pulse_envelope_test: stimulus and verdict
// Drives key-level ticks with random gaps and result stalls, sweeps the
// settings between phases and reports the checker's outcome.
// ----------------------------------------------------------------------------
module keypress_classified_pulse_envelope_test;
    import kcpe_pkg::*;

    logic              aclk = 0;
    logic              aresetn = 0;
    logic              s_tvalid = 0;
    logic              s_tready;
    logic [7:0]        s_tdata = 0;   // [0] key_down
    logic              m_tvalid;
    logic              m_tready = 0;
    logic [31:0]       m_tdata;       // [11:0] tone, [23:12] duty, [24] on, [25] long
    logic              psel = 0, penable = 0, pwrite = 0;
    logic [ADDR_W-1:0] paddr = 0;
    logic [31:0]       pwdata = 0;
    logic [31:0]       prdata;
    logic              pready;
    int                fail_count, pending;
    logic              stall_en = 1;

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    keypress_classified_pulse_envelope u_top (.*);

    kcpe_checker u_check (.*);

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 200);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 4);
    endfunction

    // Result stalls, with stretches where the sink always accepts.
    always @(negedge aclk) begin
        if (stall_en && $urandom_range(0, 3) == 0) m_tready <= 0;
        else m_tready <= 1;
    end

    task automatic wait_drained();
        while (pending != 0) @(negedge aclk);
        repeat (600) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge aclk);
        penable <= 1;
        @(negedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
        @(negedge aclk);
    endtask

    task automatic send_tick(input logic key);
        repeat (1 + gap_len()) @(negedge aclk);
        s_tvalid <= 1;
        s_tdata  <= {7'($urandom_range(0, 127)), key};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        s_tvalid <= 0;
    endtask

    // A press of the given length, release, then a stretch of released ticks.
    task automatic press(input int hold, input int after);
        repeat (hold) send_tick(1);
        repeat (after) send_tick(0);
    endtask

    task automatic set_all(input logic [15:0] thr, input logic [15:0] sl,
                           input logic [15:0] ll, input logic [7:0] rmp,
                           input logic [11:0] pk, input logic [9:0] rf,
                           input logic [9:0] df, input logic [7:0] mf);
        write_reg(REG_LONG_THR, 32'(thr));
        write_reg(REG_SHORT_LEN, 32'(sl));
        write_reg(REG_LONG_LEN, 32'(ll));
        write_reg(REG_TONE_RAMP, 32'(rmp));
        write_reg(REG_TONE_PEAK, 32'(pk));
        write_reg(REG_LED_RISE, 32'(rf));
        write_reg(REG_LED_DECAY, 32'(df));
        write_reg(REG_LED_MINF, 32'(mf));
    endtask

    initial begin
        int n;
        repeat (3) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // Directed: short press at defaults, release during a pulse, noise, then edge-case settings.
        press(3, 4);
        press(1, 2);
        wait_drained();
        set_all(0, 1, 1, 255, 4095, 1023, 1023, 255);
        wait_drained();
        set_all(4, 6, 9, 1, 4095, 0, 0, 1);
        press(2, 8);
        press(5, 11);
        wait_drained();
        set_all(65535, 20, 65535, 3, 0, 512, 300, 2);
        press(2, 6);

        // Random phases with mostly well-formed presses and short pulses.
        for (int ph = 0; ph < 5; ph++) begin
            wait_drained();
            set_all(16'($urandom_range(1, 12)), 16'($urandom_range(1, 30)),
                    16'($urandom_range(1, 40)), 8'($urandom_range(0, 255)),
                    12'($urandom_range(0, 4095)), 10'($urandom_range(0, 1023)),
                    10'($urandom_range(0, 1023)), 8'($urandom_range(0, 255)));
            stall_en = (ph != 2);
            n = 0;
            while (n < 100) begin
                int h, a;
                h = $urandom_range(0, 3) == 0 ? $urandom_range(10, 20) : $urandom_range(1, 6);
                a = $urandom_range(0, 4) == 0 ? $urandom_range(0, 3) : $urandom_range(1, 40);
                press(h, a);
                n += h + a;
            end
        end
        wait_drained();
        if (fail_count == 0) $display("Test completed successfully");
        else $display("Test completed with failures");
        $finish;
    end

    initial begin
        #50ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/kcpe_pkg.sv
rtl/core/kcpe_alu.sv
rtl/core/kcpe_regs.sv
rtl/core/keypress_classified_pulse_envelope.sv
bench/kcpe_checker.sv
bench/keypress_classified_pulse_envelope_test.sv
